// File: rtl/core/n50_length_statistic_core_defines.svh
// Assertion macros shared by the N50 length statistic core.
`ifndef N50_LENGTH_STATISTIC_CORE_DEFINES_SVH
`define N50_LENGTH_STATISTIC_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define N50LS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define N50LS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/n50ls_pkg.sv
// Package with the shared constants of the N50 length statistic core.
`default_nettype none
package n50ls_pkg;
	localparam int unsigned MAX_FRAGMENTS_DEF = 1024;
	localparam int unsigned LENGTH_BITS_DEF   = 32;
	localparam int unsigned LENGTH_W          = 32;
	localparam int unsigned N50_W             = 32;
	localparam int unsigned COUNT_W           = 11;
	localparam int unsigned TOTAL_W           = 42;
	localparam int unsigned QUEUE_DEPTH       = 4;
endpackage
`default_nettype wire

// File: rtl/core/n50ls_in_if.sv
// Fragment input channel interface.
`default_nettype none
interface n50ls_in_if;
	logic                            valid;
	logic                            ready;
	logic [n50ls_pkg::LENGTH_W-1:0]  length;
	logic                            last;

	modport source (output valid, output length, output last, input ready);
	modport sink (input valid, input length, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/n50ls_out_if.sv
// Result output channel interface.
`default_nettype none
interface n50ls_out_if;
	logic                           valid;
	logic                           ready;
	logic [n50ls_pkg::N50_W-1:0]    n50;
	logic [n50ls_pkg::COUNT_W-1:0]  fragment_count;
	logic [n50ls_pkg::TOTAL_W-1:0]  length_sum;
	logic                           overflow;
	logic                           empty_res;

	modport source (output valid, output n50, output fragment_count, output length_sum,
		output overflow, output empty_res, input ready);
	modport sink (input valid, input n50, input fragment_count, input length_sum,
		input overflow, input empty_res, output ready);
endinterface
`default_nettype wire

// File: rtl/core/n50ls_front.sv
// Front end that accepts fragments and marks each as stored or dropped.
`default_nettype none
module n50ls_front #(
	parameter int unsigned MAX_FRAGMENTS = n50ls_pkg::MAX_FRAGMENTS_DEF,
	parameter int unsigned LENGTH_BITS   = n50ls_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	n50ls_in_if.sink                    frag,
	output logic                        q_valid,
	input  wire logic                   q_ready,
	output logic [LENGTH_BITS+1:0]      q_data
);
	import n50ls_pkg::*;

	localparam int unsigned CW = $clog2(MAX_FRAGMENTS + 1);

	logic [CW-1:0]          fcnt_q;
	logic                   v_s1;
	logic [LENGTH_BITS-1:0] len_s1;
	logic                   store_s1;
	logic                   last_s1;
	logic                   take;
	logic                   store_in;

	assign frag.ready = !v_s1 || q_ready;
	assign take       = frag.valid && frag.ready;
	assign store_in   = fcnt_q < CW'(MAX_FRAGMENTS);
	assign q_valid    = v_s1;
	assign q_data     = {store_s1, last_s1, len_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			fcnt_q   <= '0;
			len_s1   <= '0;
			store_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (take) begin
				v_s1     <= 1'b1;
				len_s1   <= LENGTH_BITS'(frag.length);
				store_s1 <= store_in;
				last_s1  <= frag.last;
				if (frag.last) begin
					fcnt_q <= '0;
				end else if (store_in) begin
					fcnt_q <= fcnt_q + CW'(1);
				end
			end else if (q_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/n50ls_fifo.sv
// Short queue between the front end and the back end.
`default_nettype none
module n50ls_fifo #(
	parameter int unsigned W     = 34,
	parameter int unsigned DEPTH = n50ls_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire logic [W-1:0]  push_data,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output logic [W-1:0]       pop_data
);
	import n50ls_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = cnt_q < CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = entry_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/n50ls_back.sv
// Back end that stores lengths, shell sorts them and scans for the N50.
`default_nettype none
`include "n50_length_statistic_core_defines.svh"
module n50ls_back #(
	parameter int unsigned MAX_FRAGMENTS = n50ls_pkg::MAX_FRAGMENTS_DEF,
	parameter int unsigned LENGTH_BITS   = n50ls_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	output logic                        q_ready,
	input  wire logic [LENGTH_BITS+1:0] q_data,
	n50ls_out_if.source                 res
);
	import n50ls_pkg::*;

	localparam int unsigned AW = $clog2(MAX_FRAGMENTS);
	localparam int unsigned CW = $clog2(MAX_FRAGMENTS + 1);
	localparam int unsigned TW = LENGTH_BITS + CW;

	localparam logic [3:0] ST_LOAD      = 4'd0;
	localparam logic [3:0] ST_DECIDE    = 4'd1;
	localparam logic [3:0] ST_SORT_INIT = 4'd2;
	localparam logic [3:0] ST_RD_I      = 4'd3;
	localparam logic [3:0] ST_HELD      = 4'd4;
	localparam logic [3:0] ST_CHK       = 4'd5;
	localparam logic [3:0] ST_CMP       = 4'd6;
	localparam logic [3:0] ST_SCAN_INIT = 4'd7;
	localparam logic [3:0] ST_SCAN      = 4'd8;
	localparam logic [3:0] ST_EMIT      = 4'd9;

	logic [LENGTH_BITS-1:0] store_mem [MAX_FRAGMENTS];
	logic [LENGTH_BITS-1:0] rdata_q;

	logic [3:0]             st_q;
	logic [CW-1:0]          cnt_q;
	logic [TW-1:0]          tot_q;
	logic                   ovf_q;
	logic [CW-1:0]          gap_q;
	logic [CW-1:0]          i_q;
	logic [CW-1:0]          j_q;
	logic [CW-1:0]          k_q;
	logic [LENGTH_BITS-1:0] held_q;
	logic [TW-1:0]          acc_q;
	logic [LENGTH_BITS-1:0] n50_q;

	logic                   out_v_q;
	logic [N50_W-1:0]       out_n50_q;
	logic [COUNT_W-1:0]     out_cnt_q;
	logic [TOTAL_W-1:0]     out_tot_q;
	logic                   out_ovf_q;
	logic                   out_empty_q;

	logic [LENGTH_BITS-1:0] q_len;
	logic                   q_last;
	logic                   q_store;
	logic [CW-1:0]          jg;
	logic [CW-1:0]          gap_half;
	logic [TW-1:0]          half;
	logic [TW-1:0]          acc_nx;
	logic                   scan_done;
	logic                   emit_ok;
	logic                   is_empty;
	logic                   we;
	logic                   re;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr;
	logic [LENGTH_BITS-1:0] wdata;

	assign q_len     = q_data[LENGTH_BITS-1:0];
	assign q_last    = q_data[LENGTH_BITS];
	assign q_store   = q_data[LENGTH_BITS+1];
	assign q_ready   = st_q == ST_LOAD;
	assign jg        = j_q - gap_q;
	assign gap_half  = gap_q >> 1;
	assign half      = tot_q >> 1;
	assign acc_nx    = acc_q + TW'(rdata_q);
	assign scan_done = (acc_nx >= half) || (k_q == cnt_q - CW'(1));
	assign emit_ok   = !out_v_q || res.ready;
	assign is_empty  = (cnt_q == '0) || (tot_q == '0);

	assign res.valid          = out_v_q;
	assign res.n50            = out_n50_q;
	assign res.fragment_count = out_cnt_q;
	assign res.length_sum     = out_tot_q;
	assign res.overflow       = out_ovf_q;
	assign res.empty_res      = out_empty_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = j_q[AW-1:0];
		raddr = i_q[AW-1:0];
		wdata = held_q;
		case (st_q)
			ST_LOAD: begin
				if (q_valid && q_store) begin
					we    = 1'b1;
					waddr = cnt_q[AW-1:0];
					wdata = q_len;
				end
			end
			ST_RD_I: begin
				re = i_q < cnt_q;
			end
			ST_CHK: begin
				if (j_q >= gap_q) begin
					re    = 1'b1;
					raddr = jg[AW-1:0];
				end else begin
					we = 1'b1;
				end
			end
			ST_CMP: begin
				we = 1'b1;
				if (rdata_q < held_q) begin
					wdata = rdata_q;
				end
			end
			ST_SCAN_INIT: begin
				re    = 1'b1;
				raddr = '0;
			end
			ST_SCAN: begin
				if (!scan_done) begin
					re    = 1'b1;
					raddr = k_q[AW-1:0] + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_LOAD;
			cnt_q       <= '0;
			tot_q       <= '0;
			ovf_q       <= 1'b0;
			gap_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			held_q      <= '0;
			acc_q       <= '0;
			n50_q       <= '0;
			out_v_q     <= 1'b0;
			out_n50_q   <= '0;
			out_cnt_q   <= '0;
			out_tot_q   <= '0;
			out_ovf_q   <= 1'b0;
			out_empty_q <= 1'b0;
		end else begin
			if ((st_q == ST_EMIT) && emit_ok) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (q_store) begin
							cnt_q <= cnt_q + CW'(1);
							tot_q <= tot_q + TW'(q_len);
						end else begin
							ovf_q <= 1'b1;
						end
						if (q_last) begin
							st_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (is_empty) begin
						n50_q <= '0;
						st_q  <= ST_EMIT;
					end else begin
						st_q <= ST_SORT_INIT;
					end
				end
				ST_SORT_INIT: begin
					gap_q <= cnt_q >> 1;
					i_q   <= cnt_q >> 1;
					st_q  <= ((cnt_q >> 1) == '0) ? ST_SCAN_INIT : ST_RD_I;
				end
				ST_RD_I: begin
					if (i_q < cnt_q) begin
						j_q  <= i_q;
						st_q <= ST_HELD;
					end else if (gap_half == '0) begin
						st_q <= ST_SCAN_INIT;
					end else begin
						gap_q <= gap_half;
						i_q   <= gap_half;
					end
				end
				ST_HELD: begin
					held_q <= rdata_q;
					st_q   <= ST_CHK;
				end
				ST_CHK: begin
					if (j_q >= gap_q) begin
						st_q <= ST_CMP;
					end else begin
						i_q  <= i_q + CW'(1);
						st_q <= ST_RD_I;
					end
				end
				ST_CMP: begin
					if (rdata_q < held_q) begin
						j_q  <= jg;
						st_q <= ST_CHK;
					end else begin
						i_q  <= i_q + CW'(1);
						st_q <= ST_RD_I;
					end
				end
				ST_SCAN_INIT: begin
					k_q   <= '0;
					acc_q <= '0;
					st_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					acc_q <= acc_nx;
					if (scan_done) begin
						n50_q <= rdata_q;
						st_q  <= ST_EMIT;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						out_n50_q   <= N50_W'(n50_q);
						out_cnt_q   <= COUNT_W'(cnt_q);
						out_tot_q   <= TOTAL_W'(tot_q);
						out_ovf_q   <= ovf_q;
						out_empty_q <= is_empty;
						cnt_q       <= '0;
						tot_q       <= '0;
						ovf_q       <= 1'b0;
						st_q        <= ST_LOAD;
					end
				end
				default: begin
					st_q <= ST_LOAD;
				end
			endcase
		end
	end

	`N50LS_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CW'(MAX_FRAGMENTS), "Stored count beyond capacity.")
	`N50LS_ASSERT_IMPL(a_cmp_gap, st_q == ST_CMP, (j_q >= gap_q) && (gap_q != '0), "Compare step without a valid gap.")
	`N50LS_ASSERT_IMPL(a_scan_index, st_q == ST_SCAN, k_q < cnt_q, "Scan index past the stored count.")
	`N50LS_ASSERT_NEXT(a_emit_clear, (st_q == ST_EMIT) && emit_ok, (cnt_q == '0) && !ovf_q && res.valid, "Set not cleared after a result.")
endmodule
`default_nettype wire

// File: rtl/core/n50_length_statistic_core.sv
// Top level of the N50 length statistic core.
// Usage: fragment lengths enter on the frag channel, one transaction per fragment;
// a transaction with last set closes the set. One result transaction per set leaves
// on the res channel with the N50, the stored count, the total, and the overflow and
// empty flags. Fragments beyond MAX_FRAGMENTS in a set are dropped and flag overflow.
// While a set is loading, one fragment is taken per cycle as long as the queue has
// room; a front stage and a four-entry queue keep the input side moving while the
// back end is busy, until the queue fills. After the last fragment of a non-empty
// set the back end shell sorts the stored lengths in place in a single-port-read
// memory: each element pick passes the read, hold and check states and each inner
// compare-and-move the check and compare states. A scan over at most the stored
// count of lengths follows, then the result register is loaded; the back end
// resumes loading only after the result is registered.
// Reset clears the set count, the total and the flags; memory contents need no clear.
// When the receiver stalls, the result stays in the output register, and the next
// set loads until its own result is ready to be written.
`default_nettype none
module n50_length_statistic_core #(
	parameter int unsigned MAX_FRAGMENTS = n50ls_pkg::MAX_FRAGMENTS_DEF,
	parameter int unsigned LENGTH_BITS   = n50ls_pkg::LENGTH_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	n50ls_in_if.sink     frag,
	n50ls_out_if.source  res
);
	import n50ls_pkg::*;

	localparam int unsigned QW = LENGTH_BITS + 2;

	logic          f_valid;
	logic          f_ready;
	logic [QW-1:0] f_data;
	logic          b_valid;
	logic          b_ready;
	logic [QW-1:0] b_data;

	n50ls_front #(
		.MAX_FRAGMENTS(MAX_FRAGMENTS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.frag   (frag),
		.q_valid(f_valid),
		.q_ready(f_ready),
		.q_data (f_data)
	);

	n50ls_fifo #(
		.W    (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data)
	);

	n50ls_back #(
		.MAX_FRAGMENTS(MAX_FRAGMENTS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(b_valid),
		.q_ready(b_ready),
		.q_data (b_data),
		.res    (res)
	);
endmodule
`default_nettype wire
